>>> src/mirror_frame_transform_assert.svh
`ifndef MIRROR_FRAME_TRANSFORM_ASSERT_SVH
`define MIRROR_FRAME_TRANSFORM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MFT_AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mirror frame transform check failed");

// delayed implication, checked outside reset
`define MFT_AST_DELAY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("mirror frame transform latency check failed");

`endif

>>> src/mft_pkg.sv
package mft_pkg;

	localparam int AXIS_WORD_BITS = 16;
	localparam int REG_IDX_BITS   = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_SURF_AXIS0 = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_SURF_AXIS1 = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_SURF_AXIS2 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_CAM_AXIS0  = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_CAM_AXIS1  = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_CAM_AXIS2  = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_SURF_ORG   = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_CAM_ORG    = 3'd7;

	typedef logic [2:0][AXIS_WORD_BITS-1:0] axis_row_t;
	typedef axis_row_t [2:0] axis_mat_t;

	typedef struct packed {
		axis_mat_t   surf;
		axis_mat_t   cam;
		logic [62:0] surf_org;
		logic [62:0] cam_org;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic point;
	} tag_t;

	localparam axis_mat_t AXIS_RST = {48'h4000_0000_0000, 48'h0000_4000_0000,
		48'h0000_0000_4000};

	function automatic int mv_out_w(int in_w, int frac);
		return in_w + AXIS_WORD_BITS + 2 - frac;
	endfunction

endpackage

>>> src/mft_regs.sv
module mft_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	output mft_pkg::cfg_t       cfg
);
	import mft_pkg::*;

	logic [REG_IDX_BITS-1:0] idx;
	logic                    wr;
	cfg_t                    cfg_q;

	assign idx    = paddr[5:3];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.surf     <= AXIS_RST;
			cfg_q.cam      <= AXIS_RST;
			cfg_q.surf_org <= '0;
			cfg_q.cam_org  <= '0;
		end else if (wr) begin
			case (idx)
				REG_SURF_AXIS0: cfg_q.surf[0] <= pwdata[47:0];
				REG_SURF_AXIS1: cfg_q.surf[1] <= pwdata[47:0];
				REG_SURF_AXIS2: cfg_q.surf[2] <= pwdata[47:0];
				REG_CAM_AXIS0:  cfg_q.cam[0]  <= pwdata[47:0];
				REG_CAM_AXIS1:  cfg_q.cam[1]  <= pwdata[47:0];
				REG_CAM_AXIS2:  cfg_q.cam[2]  <= pwdata[47:0];
				REG_SURF_ORG:   cfg_q.surf_org <= pwdata[62:0];
				REG_CAM_ORG:    cfg_q.cam_org  <= pwdata[62:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SURF_AXIS0: prdata = 64'(cfg_q.surf[0]);
			REG_SURF_AXIS1: prdata = 64'(cfg_q.surf[1]);
			REG_SURF_AXIS2: prdata = 64'(cfg_q.surf[2]);
			REG_CAM_AXIS0:  prdata = 64'(cfg_q.cam[0]);
			REG_CAM_AXIS1:  prdata = 64'(cfg_q.cam[1]);
			REG_CAM_AXIS2:  prdata = 64'(cfg_q.cam[2]);
			REG_SURF_ORG:   prdata = 64'(cfg_q.surf_org);
			REG_CAM_ORG:    prdata = 64'(cfg_q.cam_org);
			default:        prdata = '0;
		endcase
	end

endmodule

>>> src/mft_matvec.sv
`include "mirror_frame_transform_assert.svh"

module mft_matvec #(
	parameter int IN_W = 22,
	parameter int FRAC = 14
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  mft_pkg::tag_t                                      tag_in,
	input  logic [2:0][IN_W-1:0]                               vec_in,
	input  mft_pkg::axis_mat_t                                 mat,
	output mft_pkg::tag_t                                      tag_out,
	output logic [2:0][mft_pkg::mv_out_w(IN_W, FRAC)-1:0]      vec_out
);
	import mft_pkg::*;

	localparam int PW = IN_W + AXIS_WORD_BITS;
	localparam int AW = PW + 2;
	localparam int OW = mv_out_w(IN_W, FRAC);
	localparam logic signed [AW-1:0] HALF = {{(AW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

	logic signed [PW-1:0] prod_s1 [3][3];
	tag_t                 tag_s1;
	logic signed [AW-1:0] acc [3];
	tag_t                 tag_s2;
	logic [2:0][OW-1:0]   vec_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[i][j] <= PW'($signed(mat[i][j])) * PW'($signed(vec_in[j]));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = AW'(prod_s1[i][0]) + AW'(prod_s1[i][1]) + AW'(prod_s1[i][2]) + HALF;
		end
	end

	// floor of (sum + half) over the fraction: drop the low bits
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vec_s2[i] <= acc[i][AW-1:FRAC];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	assign tag_out = tag_s2;
	assign vec_out = vec_s2;

	`MFT_AST_IMPL(a_mv_valid, tag_out.valid, $past(tag_in.valid, 2))

endmodule

>>> src/mft_out.sv
`include "mirror_frame_transform_assert.svh"

module mft_out #(
	parameter int COORD_BITS = 21,
	parameter int VW         = 35
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mft_pkg::tag_t                tag_in,
	input  logic [2:0][VW-1:0]           vec_in,
	input  logic [62:0]                  org,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [COORD_BITS-1:0] out_z,
	output logic                         saturated
);
	import mft_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int SW   = VW + 1;
	localparam int PADW = (3 * C > 64) ? 3 * C : 64;
	localparam logic signed [SW-1:0] HI  = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
	localparam logic signed [SW-1:0] LO  = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};
	localparam logic signed [C-1:0]  OHI = {1'b0, {(C-1){1'b1}}};
	localparam logic signed [C-1:0]  OLO = {1'b1, {(C-1){1'b0}}};

	logic [PADW-1:0]      org_w;
	logic signed [C-1:0]  org_f [3];
	logic signed [SW-1:0] addend [3];
	logic signed [SW-1:0] sum [3];
	logic signed [C-1:0]  clamp [3];
	logic [2:0]           sat;
	logic                 at_rail;

	assign org_w = PADW'(org);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			org_f[k]  = org_w[k*C +: C];
			addend[k] = tag_in.point ? SW'(org_f[k]) : '0;
			sum[k]    = SW'($signed(vec_in[k])) + addend[k];
			if (sum[k] > HI) begin
				clamp[k] = OHI;
				sat[k]   = 1'b1;
			end else if (sum[k] < LO) begin
				clamp[k] = OLO;
				sat[k]   = 1'b1;
			end else begin
				clamp[k] = sum[k][C-1:0];
				sat[k]   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_x     <= clamp[0];
		out_y     <= clamp[1];
		out_z     <= clamp[2];
		saturated <= |sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_in.valid;
		end
	end

	assign at_rail = out_x == OHI || out_x == OLO || out_y == OHI || out_y == OLO ||
		out_z == OHI || out_z == OLO;

	`MFT_AST_IMPL(a_sat_clamped, done && saturated, at_rail)

endmodule

>>> src/mirror_frame_transform.sv
// Moves a 3D point (cmd 0) or direction (cmd 1) from the surface frame into the
// camera frame. A request is taken on every clock where start is high; busy is
// always low. Each request yields one result, shown for one cycle with done high;
// the six register stages are the origin subtract, two stages for each 3x3 axis
// product (multiply, then sum and round), and the origin add with clamp. There is
// no back pressure: results must be taken in the cycle done is high. Write the
// frame registers only while no request is in flight.
`include "mirror_frame_transform_assert.svh"

module mirror_frame_transform #(
	parameter int COORD_BITS     = 21,
	parameter int AXIS_FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	input  logic signed [COORD_BITS-1:0] in_z,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [COORD_BITS-1:0] out_z,
	output logic                         saturated,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [5:0]                   paddr,
	input  logic [63:0]                  pwdata,
	output logic [63:0]                  prdata,
	output logic                         pready
);
	import mft_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int DW   = C + 1;
	localparam int TW   = mv_out_w(DW, AXIS_FRAC_BITS);
	localparam int OW   = mv_out_w(TW, AXIS_FRAC_BITS);
	localparam int PADW = (3 * C > 64) ? 3 * C : 64;

	cfg_t                cfg;
	axis_mat_t           cam_tr;
	logic                accept;
	logic [PADW-1:0]     org_w;
	logic signed [C-1:0] in_v [3];
	logic signed [C-1:0] so_f [3];
	logic [2:0][DW-1:0]  d_next;
	logic [2:0][DW-1:0]  d_s1;
	tag_t                tag_s1;
	tag_t                tag_t_s3;
	logic [2:0][TW-1:0]  t_s3;
	tag_t                tag_o_s5;
	logic [2:0][OW-1:0]  o_s5;

	mft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign org_w  = PADW'(cfg.surf_org);
	assign in_v[0] = in_x;
	assign in_v[1] = in_y;
	assign in_v[2] = in_z;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			so_f[j]   = org_w[j*C +: C];
			d_next[j] = DW'(in_v[j]) - (cmd ? DW'(0) : DW'(so_f[j]));
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				cam_tr[k][i] = cfg.cam[i][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= d_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= accept;
			tag_s1.point <= ~cmd;
		end
	end

	mft_matvec #(
		.IN_W (DW),
		.FRAC (AXIS_FRAC_BITS)
	) u_surf (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_s1),
		.vec_in  (d_s1),
		.mat     (cfg.surf),
		.tag_out (tag_t_s3),
		.vec_out (t_s3)
	);

	mft_matvec #(
		.IN_W (TW),
		.FRAC (AXIS_FRAC_BITS)
	) u_cam (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_t_s3),
		.vec_in  (t_s3),
		.mat     (cam_tr),
		.tag_out (tag_o_s5),
		.vec_out (o_s5)
	);

	mft_out #(
		.COORD_BITS (C),
		.VW         (OW)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_o_s5),
		.vec_in    (o_s5),
		.org       (cfg.cam_org),
		.done      (done),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.saturated (saturated)
	);

	`MFT_AST_DELAY(a_latency, start && !busy, 6, done)
	`MFT_AST_IMPL(a_no_orphan, done, $past(start && !busy, 6))

endmodule
